### hdl/plmc_pkg.sv
// Shared types, register indexes and the gray conversion for the local minimum contrast unit.
package plmc_pkg;

	// Pixel and gray value types.
	typedef logic [7:0] chan_t;
	typedef logic [7:0] gray_t;

	// Window cells: left column (0..2) then centre column (3..5), top to bottom.
	typedef logic [5:0][7:0] win_t;

	// Which neighbours of the centre lie inside the frame.
	typedef struct packed {
		logic has_l;
		logic has_r;
		logic has_t;
		logic has_b;
	} nbr_mask_t;

	// Configuration register indexes.
	localparam logic CFG_FRAME_WIDTH  = 1'b0;
	localparam logic CFG_FRAME_HEIGHT = 1'b1;

	// Field widths and register resets.
	localparam int CFG_DATA_W   = 12;
	localparam int FW_REG_W     = 11;
	localparam int FH_REG_W     = 12;
	localparam int OUT_COL_W    = 10;
	localparam int ROW_W        = 12;
	localparam logic [FW_REG_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_REG_W-1:0] FH_RESET = 12'd480;
	localparam logic [ROW_W-1:0]    ROW_TOP  = 12'd4095;

	// Action codes of an input item.
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Gray conversion: (11r + 16g + 5b) / 32, rounded down.
	function automatic gray_t gray_of(input chan_t r, input chan_t g, input chan_t b);
		logic [12:0] sum;
		sum = 13'd11 * 13'(r) + 13'd16 * 13'(g) + 13'd5 * 13'(b);
		return sum[12:5];
	endfunction

endpackage

### hdl/plmc_if.sv
// Channel interfaces of the local minimum contrast unit: pixel input, result output, configuration.
interface plmc_pix_if;
	import plmc_pkg::*;
	logic  valid;
	logic  ready;
	logic  action;
	chan_t red;
	chan_t green;
	chan_t blue;
	modport source (output valid, action, red, green, blue, input ready);
	modport sink   (input valid, action, red, green, blue, output ready);
endinterface

interface plmc_res_if;
	import plmc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [OUT_COL_W-1:0] column;
	logic [ROW_W-1:0]     row;
	gray_t                gray;
	gray_t                contrast;
	logic                 last_of_frame;
	modport source (output valid, column, row, gray, contrast, last_of_frame, input ready);
	modport sink   (input valid, column, row, gray, contrast, last_of_frame, output ready);
endinterface

interface plmc_cfg_if;
	import plmc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hdl/plmc_nbr_min.sv
// Neighbour minimum over the 3x3 window and the resulting contrast of the centre pixel.
module plmc_nbr_min (
	input  plmc_pkg::win_t      win,
	input  plmc_pkg::gray_t     new_top,
	input  plmc_pkg::gray_t     new_mid,
	input  plmc_pkg::gray_t     new_bot,
	input  plmc_pkg::nbr_mask_t mask,
	output plmc_pkg::gray_t     contrast
);
	import plmc_pkg::*;

	gray_t [7:0] cand;
	logic  [7:0] cand_en;
	gray_t       centre;
	gray_t       min_val;

	// Eight neighbours, each enabled only when it lies inside the frame.
	always_comb begin
		centre     = win[4];
		cand[0]    = win[3];
		cand_en[0] = mask.has_t;
		cand[1]    = win[5];
		cand_en[1] = mask.has_b;
		cand[2]    = win[1];
		cand_en[2] = mask.has_l;
		cand[3]    = win[0];
		cand_en[3] = mask.has_l & mask.has_t;
		cand[4]    = win[2];
		cand_en[4] = mask.has_l & mask.has_b;
		cand[5]    = new_mid;
		cand_en[5] = mask.has_r;
		cand[6]    = new_top;
		cand_en[6] = mask.has_r & mask.has_t;
		cand[7]    = new_bot;
		cand_en[7] = mask.has_r & mask.has_b;
	end

	// Minimum of the enabled neighbours; with none enabled it stays at full scale,
	// which never lies below the centre.
	always_comb begin
		min_val = 8'hFF;
		for (int i = 0; i < 8; i++) begin
			if (cand_en[i] && (cand[i] < min_val)) begin
				min_val = cand[i];
			end
		end
		contrast = (min_val < centre) ? (centre - min_val) : centre;
	end

endmodule

### hdl/pixel_local_min_contrast_unit.sv
// Top level of the local minimum contrast unit: counters, line stores, window and result register.
//
// Takes one pixel or drain item per clock cycle unless a held result stalls it, and gives at most
// one result per item, in raster order, one row and one pixel behind the input; after the last
// pixel of a frame, width+1 drain items push out the remaining results. An accepted item reads
// both line stores at its column, moves through one stage in which the window, the neighbour
// minimum and the line store write-back are done, and lands in the output register. The sustained
// rate is one item per cycle while results are taken, set by the single read and single write port
// of each line store; an item read at the column that the item ahead is writing gets the written
// data forwarded. The line stores are not cleared after reset, so the block is ready at once.
// Configuration writes are taken in every cycle and should be made only while the block is idle.
module pixel_local_min_contrast_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	plmc_pix_if.sink    pix,
	plmc_res_if.source  res,
	plmc_cfg_if.sink    cfg
);
	import plmc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > FW_REG_W) ? CW + 1 : FW_REG_W;
	localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
	localparam logic [WW-1:0] MINW = WW'(2);

	// Configuration registers.
	logic [FW_REG_W-1:0] width_q;
	logic [FH_REG_W-1:0] height_q;

	// Position counters.
	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	// Effective frame size.
	logic [WW-1:0]    eff_w;
	logic [ROW_W-1:0] eff_h;

	// Control of the item being taken.
	logic        pix_acc;
	logic        emit_a;
	logic        last_a;
	logic        in_wrap_a;
	logic        out_wrap_a;
	nbr_mask_t   mask_a;
	gray_t       gin_a;

	// Stage one.
	logic        v_s1;
	logic        emit_s1;
	logic        last_s1;
	nbr_mask_t   mask_s1;
	logic [CW-1:0]    col_s1;
	logic [CW-1:0]    oc_s1;
	logic [ROW_W-1:0] orow_s1;
	gray_t       gin_s1;
	gray_t       top_s1;
	gray_t       mid_s1;
	logic        s1_adv;
	logic        out_free;
	logic        fwd;

	// Line stores and window.
	gray_t       upper_mem [MAX_WIDTH];
	gray_t       middle_mem [MAX_WIDTH];
	win_t        win_q;
	gray_t       contrast_s1;

	// Output register.
	logic                 out_valid_q;
	logic [OUT_COL_W-1:0] out_col_q2;
	logic [ROW_W-1:0]     out_row_q2;
	gray_t                out_gray_q;
	gray_t                out_con_q;
	logic                 out_last_q;

	// Configuration port: always ready.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FW_RESET;
			height_q <= FH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FRAME_WIDTH:  width_q  <= cfg.data[FW_REG_W-1:0];
				CFG_FRAME_HEIGHT: height_q <= cfg.data[FH_REG_W-1:0];
				default:          width_q  <= width_q;
			endcase
		end
	end

	// Clamp the frame size to its legal range.
	always_comb begin
		eff_w = WW'(width_q);
		if (eff_w < MINW) begin
			eff_w = MINW;
		end else if (eff_w > MAXW) begin
			eff_w = MAXW;
		end
		eff_h = (height_q < 12'd2) ? 12'd2 : height_q;
	end

	// Handshake: stage one moves on when its item has no result or the output register is free.
	assign out_free = !out_valid_q || res.ready;
	assign s1_adv   = v_s1 && (!emit_s1 || out_free);
	assign pix.ready = !v_s1 || s1_adv;
	assign pix_acc  = pix.valid && pix.ready;

	// Position control of the item being taken, from the counters and the frame size, and its gray value.
	always_comb begin
		emit_a = (in_row_q >= 12'd2) || ((in_row_q == 12'd1) && (in_col_q != '0));
		mask_a.has_l = (out_col_q != '0);
		mask_a.has_r = ((WW'(out_col_q) + WW'(1)) < eff_w);
		mask_a.has_t = (out_row_q != '0);
		mask_a.has_b = (({1'b0, out_row_q} + 13'd1) < {1'b0, eff_h});
		out_wrap_a   = !mask_a.has_r;
		last_a       = out_wrap_a && !mask_a.has_b;
		in_wrap_a    = ((WW'(in_col_q) + WW'(1)) >= eff_w);
		gin_a        = (pix.action == ACT_PIXEL) ? gray_of(pix.red, pix.green, pix.blue) : '0;
	end

	// Counter update at each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (pix_acc) begin
			priority if (emit_a && last_a) begin
				in_col_q <= '0;
				in_row_q <= '0;
			end else if (in_wrap_a) begin
				in_col_q <= '0;
				if (in_row_q != ROW_TOP) begin
					in_row_q <= in_row_q + 12'd1;
				end
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (emit_a) begin
				priority if (last_a) begin
					out_col_q <= '0;
					out_row_q <= '0;
				end else if (out_wrap_a) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 12'd1;
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= pix.valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			emit_s1 <= emit_a;
			last_s1 <= last_a;
			mask_s1 <= mask_a;
			col_s1  <= in_col_q;
			oc_s1   <= out_col_q;
			orow_s1 <= out_row_q;
			gin_s1  <= gin_a;
		end
	end

	// Line stores: read at the taken item's column, write back as stage one moves on.
	// A read of the column being written gets the new data.
	assign fwd = s1_adv && (col_s1 == in_col_q);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upper_mem[col_s1]  <= mid_s1;
			middle_mem[col_s1] <= gin_s1;
		end
		if (pix_acc) begin
			if (fwd) begin
				top_s1 <= mid_s1;
				mid_s1 <= gin_s1;
			end else begin
				top_s1 <= upper_mem[in_col_q];
				mid_s1 <= middle_mem[in_col_q];
			end
		end
	end

	// Neighbour minimum and contrast.
	plmc_nbr_min u_nbr_min (
		.win      (win_q),
		.new_top  (top_s1),
		.new_mid  (mid_s1),
		.new_bot  (gin_s1),
		.mask     (mask_s1),
		.contrast (contrast_s1)
	);

	// Window shift: the centre column moves left and the new column enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= gin_s1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_col_q2 <= OUT_COL_W'(oc_s1);
			out_row_q2 <= orow_s1;
			out_gray_q <= win_q[4];
			out_con_q  <= contrast_s1;
			out_last_q <= last_s1;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.column        = out_col_q2;
	assign res.row           = out_row_q2;
	assign res.gray          = out_gray_q;
	assign res.contrast      = out_con_q;
	assign res.last_of_frame = out_last_q;

	// A stalled stage one never takes a new item.
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_adv) |-> !pix_acc)
		else $error("item taken while stage one is stalled");

	// The item with the final result of a frame restarts all position counters.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && emit_a && last_a) |=>
		(in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
		else $error("position counters not restarted after end of frame");

	// A new result appears only from a stage one item that has one.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_adv && emit_s1))
		else $error("result shown without a producing item");

endmodule

### tb/plmc_result_checker.sv
// Result checker for the local minimum contrast unit: predicts each result item and compares it.
`timescale 1ns / 1ps
module plmc_result_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	plmc_pix_if  pix,
	plmc_res_if  res,
	plmc_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding,
	output logic at_frame_start
);
	import plmc_pkg::*;

	// One predicted result item.
	typedef struct {
		logic [OUT_COL_W-1:0] column;
		logic [ROW_W-1:0]     row;
		gray_t                gray;
		gray_t                contrast;
		logic                 last_of_frame;
	} result_t;

	result_t expected_results[$];
	result_t oldest;

	// Shadow registers, line stores, window and position counters.
	logic [FW_REG_W-1:0] width_reg;
	logic [FH_REG_W-1:0] height_reg;
	gray_t upper_row [MAX_WIDTH];
	gray_t middle_row [MAX_WIDTH];
	win_t  cells;
	int    in_col, in_row, out_col, out_row;

	function automatic int clamp_dim(input int value, input int lo, input int hi);
		if (value < lo) return lo;
		if (value > hi) return hi;
		return value;
	endfunction

	function automatic int lower_of(input int a, input int b);
		return (b < a) ? b : a;
	endfunction

	// Append one predicted item at the tail of the expected queue.
	task automatic enqueue_result(input result_t item);
		expected_results.insert(expected_results.size(), item);
	endtask

	// Report and count one field that differs from the prediction.
	task automatic compare_field(input string field, input int want, input int got);
		if (got != want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Advance the predicted block by one accepted item and queue the result it causes.
	task automatic predict_contrast(input logic action, input chan_t r, input chan_t g,
			input chan_t b);
		int        w, h, col, centre, nmin, contrast;
		gray_t     gin, top_g, mid_g;
		nbr_mask_t nb;
		logic      emit, last_pix;
		result_t   item;
		w = clamp_dim(int'(width_reg), 2, MAX_WIDTH);
		h = clamp_dim(int'(height_reg), 2, int'(ROW_TOP));
		gin = '0;
		if (action == ACT_PIXEL)
			gin = gray_t'((11 * int'(r) + 16 * int'(g) + 5 * int'(b)) >> 5);
		col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
		top_g = upper_row[col];
		mid_g = middle_row[col];
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		last_pix = 1'b0;

		// Neighbour minimum over the cells that lie inside the frame.
		if (emit) begin
			nb.has_l = out_col > 0;
			nb.has_r = out_col + 1 < w;
			nb.has_t = out_row > 0;
			nb.has_b = out_row + 1 < h;
			last_pix = (out_col + 1 >= w) && (out_row + 1 >= h);
			centre = int'(cells[4]);
			nmin = 256;
			if (nb.has_t) nmin = lower_of(nmin, cells[3]);
			if (nb.has_b) nmin = lower_of(nmin, cells[5]);
			if (nb.has_l) begin
				nmin = lower_of(nmin, cells[1]);
				if (nb.has_t) nmin = lower_of(nmin, cells[0]);
				if (nb.has_b) nmin = lower_of(nmin, cells[2]);
			end
			if (nb.has_r) begin
				nmin = lower_of(nmin, mid_g);
				if (nb.has_t) nmin = lower_of(nmin, top_g);
				if (nb.has_b) nmin = lower_of(nmin, gin);
			end
			contrast = (nmin < centre) ? centre - nmin : centre;
			item.column = OUT_COL_W'(out_col);
			item.row = ROW_W'(out_row);
			item.gray = gray_t'(centre);
			item.contrast = gray_t'(contrast);
			item.last_of_frame = last_pix;
			enqueue_result(item);
			if (last_pix) begin
				out_col = 0;
				out_row = 0;
			end else if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end

		// Shift the window and write back the line stores.
		cells[0] = cells[3];
		cells[1] = cells[4];
		cells[2] = cells[5];
		cells[3] = top_g;
		cells[4] = mid_g;
		cells[5] = gin;
		upper_row[col] = mid_g;
		middle_row[col] = gin;

		// Input position; the row saturates at its top value.
		if (emit && last_pix) begin
			in_col = 0;
			in_row = 0;
		end else if (in_col + 1 >= w) begin
			in_col = 0;
			if (in_row < int'(ROW_TOP)) in_row++;
		end else begin
			in_col++;
		end
	endtask

	// Watch the three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = FW_RESET;
			height_reg = FH_RESET;
			cells = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			expected_results.delete();
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
		end else begin
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result item at column %0d row %0d with none expected",
						$time, res.column, res.row);
				end else begin
					oldest = expected_results.pop_front();
					compare_field("column", oldest.column, res.column);
					compare_field("row", oldest.row, res.row);
					compare_field("gray", oldest.gray, res.gray);
					compare_field("contrast", oldest.contrast, res.contrast);
					compare_field("last_of_frame", oldest.last_of_frame, res.last_of_frame);
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_FRAME_WIDTH) width_reg = cfg.data[FW_REG_W-1:0];
				else height_reg = cfg.data[FH_REG_W-1:0];
			end
			if (pix.valid && pix.ready)
				predict_contrast(pix.action, pix.red, pix.green, pix.blue);
		end
		outstanding = expected_results.size();
		at_frame_start = (in_col == 0) && (in_row == 0);
	end

endmodule

### tb/tb_pixel_local_min_contrast_unit.sv
// Testbench top for the local minimum contrast unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_pixel_local_min_contrast_unit;
	import plmc_pkg::*;

	localparam int MAX_W          = 1024;
	localparam int RANDOM_ITEMS   = 1550;
	localparam int IDLE_PCT       = 18;
	localparam int SETTLE_CYCLES  = 10;
	localparam int HOLDOFF_CYCLES = 200;
	localparam int STALL_LIMIT    = 4000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	logic at_frame_start;
	int   gap_pct = IDLE_PCT;
	int   holdoff_req;
	int   holdoff_seen;
	int   holdoff_left;
	int   stall_cycles;
	int   items_sent;
	int   frame_w;
	int   frame_h;

	plmc_pix_if pix ();
	plmc_res_if res ();
	plmc_cfg_if cfg ();

	pixel_local_min_contrast_unit #(
		.MAX_WIDTH(MAX_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.res    (res),
		.cfg    (cfg)
	);

	plmc_result_checker #(
		.MAX_WIDTH(MAX_W)
	) result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix            (pix),
		.res            (res),
		.cfg            (cfg),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.at_frame_start (at_frame_start)
	);

	// 20 ns clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Result receiver: random stalls, and one long hold-off when asked for.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req != holdoff_seen) begin
				holdoff_seen = holdoff_req;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				res.ready = 1'b0;
			end else begin
				res.ready = ($urandom_range(99) >= gap_pct);
			end
		end
	end

	// Watchdog: ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready)
				|| (cfg.valid && cfg.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("pixel_local_min_contrast_unit verification failed");
			$finish;
		end
	end

	function automatic int clamp_dim(input int value, input int lo, input int hi);
		if (value < lo) return lo;
		if (value > hi) return hi;
		return value;
	endfunction

	// Channel value for a frame: full random, black or white only, or mostly one color.
	function automatic chan_t pick_chan(input int mode, input chan_t base);
		if (mode == 1) return $urandom_range(1) ? 8'd255 : 8'd0;
		if (mode == 2 && $urandom_range(3) != 0) return base;
		return chan_t'($urandom);
	endfunction

	// Offer one item after an occasional gap and hold it until it is taken.
	task automatic send_item(input logic action, input chan_t r, input chan_t g, input chan_t b);
		if ($urandom_range(99) < gap_pct)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		pix.valid = 1'b1;
		pix.action = action;
		pix.red = r;
		pix.green = g;
		pix.blue = b;
		do @(posedge clk); while (!pix.ready);
		@(negedge clk);
		pix.valid = 1'b0;
		items_sent++;
	endtask

	task automatic write_reg(input logic idx, input int value);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Wait until every predicted result has arrived and the pipeline is empty.
	task automatic settle();
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input int width_data, input int height_data);
		settle();
		write_reg(CFG_FRAME_WIDTH, width_data);
		write_reg(CFG_FRAME_HEIGHT, height_data);
		frame_w = clamp_dim(width_data, 2, MAX_W);
		frame_h = clamp_dim(height_data, 2, int'(ROW_TOP));
	endtask

	// One whole frame plus its drain items, with a little noise in both parts.
	task automatic run_frame(input int mode);
		int    pixels;
		chan_t base_r, base_g, base_b;
		base_r = chan_t'($urandom);
		base_g = chan_t'($urandom);
		base_b = chan_t'($urandom);
		pixels = frame_w * frame_h;
		for (int k = 0; k < pixels + frame_w + 1; k++) begin
			if (k < pixels) begin
				if ($urandom_range(24) == 0)
					send_item(ACT_DRAIN, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
				else
					send_item(ACT_PIXEL, pick_chan(mode, base_r), pick_chan(mode, base_g),
						pick_chan(mode, base_b));
			end else if ($urandom_range(7) == 0) begin
				send_item(ACT_PIXEL, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			end else begin
				send_item(ACT_DRAIN, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
			end
		end
	endtask

	initial begin
		int frame_no;
		int pick;
		arst_n = 1'b0;
		pix.valid = 1'b0;
		pix.action = ACT_PIXEL;
		pix.red = '0;
		pix.green = '0;
		pix.blue = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_FRAME_WIDTH;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A 3x3 frame: channel extremes, a drain inside the frame, flat neighbours.
		configure(3, 3);
		send_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0);
		send_item(ACT_PIXEL, 8'd255, 8'd0, 8'd0);
		send_item(ACT_PIXEL, 8'd0, 8'd255, 8'd0);
		send_item(ACT_PIXEL, 8'd0, 8'd0, 8'd255);
		send_item(ACT_DRAIN, 8'd255, 8'd255, 8'd255);
		send_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(ACT_PIXEL, 8'd40, 8'd40, 8'd40);
		send_item(ACT_PIXEL, 8'd40, 8'd40, 8'd40);

		// Drain part, with a pixel where a drain is due.
		send_item(ACT_DRAIN, 8'd0, 8'd0, 8'd0);
		send_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(ACT_DRAIN, 8'd0, 8'd0, 8'd0);
		send_item(ACT_DRAIN, 8'd0, 8'd0, 8'd0);

		// Width changed in the middle of a frame; drains finish the frame.
		for (int k = 0; k < 5; k++)
			send_item(ACT_PIXEL, chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
		settle();
		write_reg(CFG_FRAME_WIDTH, 2);
		frame_w = 2;
		while (!at_frame_start) send_item(ACT_DRAIN, 8'd0, 8'd0, 8'd0);

		// Sizes clamped up to the smallest frame.
		configure(1, 0);
		run_frame(0);
		configure(0, 1);
		run_frame(1);

		// Random frames, mostly small; one long receiver hold-off and a stretch with no idling.
		frame_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			gap_pct = (frame_no >= 6 && frame_no < 9) ? 0 : IDLE_PCT;
			pick = $urandom_range(99);
			if (frame_no == 3)
				configure(24, 8);
			else if (pick < 75)
				configure($urandom_range(2, 9), $urandom_range(2, 6));
			else if (pick < 93)
				configure($urandom_range(10, 40), $urandom_range(2, 4));
			else
				configure($urandom_range(0, 1), $urandom_range(0, 3));
			if (frame_no == 3) holdoff_req++;
			run_frame($urandom_range(2));
			frame_no++;
		end
		gap_pct = IDLE_PCT;

		// Let the last results come out, then give the verdict.
		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("pixel_local_min_contrast_unit verification clean");
		else
			$display("pixel_local_min_contrast_unit verification failed");
		$finish;
	end

endmodule
